/* hdl/bmpds_pkg.sv */
package bmpds_pkg;

    // framebuffer geometry defaults
    localparam int FB_WIDTH_DEF  = 640;
    localparam int FB_HEIGHT_DEF = 480;

    // file layout
    localparam int PIXEL_START = 54;
    localparam int WIDTH_POS   = 18;
    localparam int HEIGHT_POS  = 22;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int HDR_POS_W   = 6;
    localparam int DIM_W       = 16;
    localparam int ROW_BYTE_W  = 18;
    localparam int START_ROW_W = 9;
    localparam int START_COL_W = 10;
    localparam int SCALE_W     = 2;
    localparam int FB_ADDR_W   = 19;
    localparam int PIXEL_W     = 24;
    localparam int SCREEN_W    = 17;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int M_DATA_W    = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ROW  = 2'd0,
        CFG_START_COL  = 2'd1,
        CFG_SCALE_LOG2 = 2'd2
    } cfg_index_t;

    // Merge one little-endian header byte into a 16-bit dimension.
    // Upper bytes saturate; a set sign bit makes the dimension zero.
    function automatic logic [DIM_W-1:0] take_header_byte(
        input logic [DIM_W-1:0]  cur,
        input logic [1:0]        off,
        input logic [BYTE_W-1:0] b
    );
        logic [DIM_W-1:0] res;
        res = cur;
        case (off)
            2'd0: res = {8'd0, b};
            2'd1: res = {b, cur[7:0]};
            2'd2:
            begin
                if (b != 8'd0)
                    res = 16'hFFFF;
            end
            default:
            begin
                if (b[7])
                    res = 16'd0;
                else if (b != 8'd0)
                    res = 16'hFFFF;
            end
        endcase
        return res;
    endfunction

    // Row length in the file: 3 bytes a pixel, padded to a multiple of four.
    function automatic logic [ROW_BYTE_W-1:0] row_size_of(input logic [DIM_W-1:0] w);
        logic [ROW_BYTE_W-1:0] raw;
        raw = ROW_BYTE_W'(w) + ROW_BYTE_W'({w, 1'b0}) + ROW_BYTE_W'(3);
        return {raw[ROW_BYTE_W-1:2], 2'b00};
    endfunction

endpackage

/* hdl/bmp_downscale_to_framebuffer.sv */
// BMP downscaler: turns a 24-bit BMP byte stream into framebuffer writes.
//
// Input channel s_*: one file byte per beat in s_tdata[7:0]; s_tuser high marks
// byte 0 of a new file and restarts decoding on that beat. Without a mark after
// reset the first byte is taken as byte 0.
// Output channel m_*: one framebuffer write per kept pixel, address in
// m_tdata[18:0] (row * FB_WIDTH + col), pixel in m_tdata[42:19] (blue, green,
// red from high to low). Header bytes, row padding, skipped rows and columns,
// pixels off screen and bytes past the last row give no beat.
// Config channel cfg_*: index 0 start_row, 1 start_col, 2 scale_log2 (reduction
// factor 2^scale_log2); cfg_ready is always high. Write only while idle.
//
// Throughput: one byte per cycle while the output is not stalled, set by the byte
// counters of the decoder. Path: the edge that accepts the red byte of a pixel
// loads the decode/clip register (stage A); the address multiply-add then fills
// the output register (stage B), which drives m_tvalid.
// Stall: when m_tready is low with a beat waiting, the whole two-stage pipe
// holds and s_tready drops in the same cycle; nothing is lost.
// Reset (rst_n low, async): decoder and configuration registers go to zero,
// scale_log2 to 1, both pipeline stages empty; stage data registers are not reset.
module bmp_downscale_to_framebuffer
    import bmpds_pkg::*;
#(
    parameter int FB_WIDTH  = FB_WIDTH_DEF,
    parameter int FB_HEIGHT = FB_HEIGHT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] file_byte
    input  logic                   s_tuser,   // [0] first_byte
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // [18:0] fb_address, [42:19] pixel_value
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ROW_W = $clog2(FB_HEIGHT);
    localparam int COL_W = $clog2(FB_WIDTH);
    localparam int SUM_W = (ROW_W + COL_W > FB_ADDR_W) ? ROW_W + COL_W : FB_ADDR_W;

    // configuration
    logic [START_ROW_W-1:0] start_row_reg;
    logic [START_COL_W-1:0] start_col_reg;
    logic [SCALE_W-1:0]     scale_reg;

    // decoder state
    logic [HDR_POS_W-1:0]  header_pos_reg, header_pos_next;
    logic [DIM_W-1:0]      width_reg, width_next;
    logic [DIM_W-1:0]      height_reg, height_next;
    logic [DIM_W-1:0]      file_row_reg, file_row_next;
    logic [ROW_BYTE_W-1:0] row_byte_reg, row_byte_next;
    logic [ROW_BYTE_W-1:0] row_size_reg, row_size_next;
    logic [1:0]            phase_reg, phase_next;    // row_byte mod 3
    logic [DIM_W-1:0]      px_reg, px_next;          // row_byte / 3
    logic [BYTE_W-1:0]     blue_reg, blue_next;
    logic [BYTE_W-1:0]     green_reg, green_next;
    logic                  done_reg, done_next;

    // stage A: clipped screen position
    logic                  a_valid_reg, a_valid_next;
    logic [ROW_W-1:0]      a_row_reg;
    logic [COL_W-1:0]      a_col_reg;
    logic [PIXEL_W-1:0]    a_pixel_reg;

    // stage B: output beat
    logic                  m_valid_reg;
    logic [FB_ADDR_W-1:0]  m_addr_reg;
    logic [PIXEL_W-1:0]    m_pixel_reg;

    logic                  advance;
    logic                  take;
    logic [BYTE_W-1:0]     in_byte;
    logic [SCREEN_W-1:0]   srow, scol;
    logic [SUM_W-1:0]      addr_sum;

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = advance;
    assign take      = s_tvalid && advance;
    assign in_byte   = s_tdata[7:0];
    assign cfg_ready = 1'b1;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W - FB_ADDR_W - PIXEL_W){1'b0}}, m_pixel_reg, m_addr_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= '0;
            start_col_reg <= '0;
            scale_reg     <= SCALE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_ROW:  start_row_reg <= cfg_data[START_ROW_W-1:0];
                CFG_START_COL:  start_col_reg <= cfg_data[START_COL_W-1:0];
                CFG_SCALE_LOG2: scale_reg     <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // decode of one byte
    always_comb
    begin
        logic [HDR_POS_W-1:0] hp;
        logic [2:0]           mask;
        logic [DIM_W-1:0]     kept_w, kept_h, px_k, row_k;
        logic [DIM_W:0]       row_plus;
        logic [ROW_BYTE_W:0]  pos_plus;
        logic                 restart;

        restart = s_tuser;
        hp      = restart ? '0 : header_pos_reg;

        header_pos_next = hp;
        width_next      = restart ? '0 : width_reg;
        height_next     = restart ? '0 : height_reg;
        file_row_next   = restart ? '0 : file_row_reg;
        row_byte_next   = restart ? '0 : row_byte_reg;
        phase_next      = restart ? '0 : phase_reg;
        px_next         = restart ? '0 : px_reg;
        blue_next       = restart ? '0 : blue_reg;
        green_next      = restart ? '0 : green_reg;
        done_next       = restart ? 1'b0 : done_reg;
        row_size_next   = row_size_reg;

        mask     = 3'((4'd1 << scale_reg) - 4'd1);
        kept_w   = width_reg >> scale_reg;
        kept_h   = height_reg >> scale_reg;
        px_k     = px_reg >> scale_reg;
        row_k    = file_row_reg >> scale_reg;
        row_plus = {1'b0, file_row_reg} + 1'b1;
        pos_plus = {1'b0, row_byte_reg} + 1'b1;

        srow = SCREEN_W'(start_row_reg) + SCREEN_W'(kept_h) - SCREEN_W'(1) - SCREEN_W'(row_k);
        scol = SCREEN_W'(start_col_reg) + SCREEN_W'(px_k);

        a_valid_next = 1'b0;

        if (hp < HDR_POS_W'(PIXEL_START))
        begin
            if (hp >= HDR_POS_W'(WIDTH_POS) && hp <= HDR_POS_W'(WIDTH_POS + 3))
                width_next = take_header_byte(width_next, hp[1:0] - 2'd2, in_byte);
            if (hp >= HDR_POS_W'(HEIGHT_POS) && hp <= HDR_POS_W'(HEIGHT_POS + 3))
                height_next = take_header_byte(height_next, hp[1:0] - 2'd2, in_byte);
            header_pos_next = hp + 1'b1;
            if (hp == HDR_POS_W'(PIXEL_START - 1))
            begin
                // the header is complete here; the dimensions are final
                row_size_next = row_size_of(width_reg);
                if (kept_w == '0 || kept_h == '0)
                    done_next = 1'b1;
            end
        end
        else if (!done_reg)
        begin
            case (phase_reg)
                2'd0: blue_next  = in_byte;
                2'd1: green_next = in_byte;
                default:
                begin
                    // red byte closes a pixel
                    if (px_reg < width_reg &&
                        (px_reg[2:0] & mask) == 3'd0 && px_k < kept_w &&
                        (file_row_reg[2:0] & mask) == 3'd0 && row_k < kept_h &&
                        srow < SCREEN_W'(FB_HEIGHT) && scol < SCREEN_W'(FB_WIDTH))
                        a_valid_next = 1'b1;
                end
            endcase

            if (pos_plus >= {1'b0, row_size_reg})
            begin
                row_byte_next = '0;
                phase_next    = '0;
                px_next       = '0;
                if (row_plus >= {1'b0, height_reg})
                    done_next = 1'b1;
                else
                    file_row_next = row_plus[DIM_W-1:0];
            end
            else
            begin
                row_byte_next = pos_plus[ROW_BYTE_W-1:0];
                if (phase_reg == 2'd2)
                begin
                    phase_next = '0;
                    px_next    = px_reg + 1'b1;
                end
                else
                    phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            file_row_reg   <= '0;
            row_byte_reg   <= '0;
            row_size_reg   <= '0;
            phase_reg      <= '0;
            px_reg         <= '0;
            blue_reg       <= '0;
            green_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else if (take)
        begin
            header_pos_reg <= header_pos_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            file_row_reg   <= file_row_next;
            row_byte_reg   <= row_byte_next;
            row_size_reg   <= row_size_next;
            phase_reg      <= phase_next;
            px_reg         <= px_next;
            blue_reg       <= blue_next;
            green_reg      <= green_next;
            done_reg       <= done_next;
        end
    end

    // stage A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= s_tvalid && a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_row_reg   <= srow[ROW_W-1:0];
            a_col_reg   <= scol[COL_W-1:0];
            a_pixel_reg <= {blue_reg, green_reg, in_byte};
        end
    end

    // stage B: address = row * FB_WIDTH + col
    assign addr_sum = SUM_W'(a_row_reg) * SUM_W'(FB_WIDTH) + SUM_W'(a_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (advance)
            m_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_addr_reg  <= addr_sum[FB_ADDR_W-1:0];
            m_pixel_reg <= a_pixel_reg;
        end
    end

    // checks
    a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
        header_pos_reg <= HDR_POS_W'(PIXEL_START))
        else $error("header position past pixel start");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("pixel phase out of range");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        row_byte_reg == '0 |-> (phase_reg == 2'd0 && px_reg == '0))
        else $error("row counters out of step");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (32'(a_row_reg) < FB_HEIGHT && 32'(a_col_reg) < FB_WIDTH))
        else $error("unclipped write in pipeline");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("byte accepted during output stall");

endmodule
